// File: rtl/core/dmwc_pkg.sv
// dmwc_pkg: shared types and constants of the direct-mapped write-back word cache
// item layouts of both channels, line layout, operation and result codes
// no dependencies
package dmwc_pkg;

    // line count is a power of two, the line index is address bits above bit 1
    localparam int NUM_LINES = 64;
    localparam int IDX_W     = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

    localparam logic [31:0] FULL_MASK = 32'hffff_ffff;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;
    localparam logic [1:0] MODE_FILL  = 2'd3;

    localparam logic [1:0] KIND_BUS_WRITE = 2'd0;
    localparam logic [1:0] KIND_BUS_READ  = 2'd1;
    localparam logic [1:0] KIND_READ_DATA = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [31:0] write_mask;
        logic        cacheable;
        logic [31:0] memory_data;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] out_address;
        logic [31:0] out_data;
        logic [31:0] out_mask;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] word;
        logic [31:0] mask;
        logic        dirty;
    } line_t;

endpackage

// File: rtl/core/direct_mapped_writeback_word_cache_unit.sv
// direct_mapped_writeback_word_cache_unit: direct-mapped write-back cache, one word per line
// line store in one synchronous memory, sequencer, output register
// depends on dmwc_pkg
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  req     | in        | req_valid/req_stall | dmwc_pkg::req_t
//  rsp     | out       | rsp_valid/rsp_stall | dmwc_pkg::rsp_t
//
// read, write and fill items: the accept cycle reads the line, the update state S_EXEC
// writes it back where the item changes it, then S_EMIT loads each result
// flush reads each line from memory once, in index order, and waits while rsp stalls
// reset clears all lines at once through a per-line written flag; no clearing pass
// req_stall is high from the cycle after an item is accepted until its last result,
// if it has any, has been loaded into the output register
module direct_mapped_writeback_word_cache_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  dmwc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output dmwc_pkg::rsp_t rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT,
        S_FLUSH_CHK,
        S_FLUSH_END
    } state_t;

    state_t                             state_reg, state_next;
    dmwc_pkg::req_t                     item_reg, item_next;
    logic [dmwc_pkg::IDX_W-1:0]         idx_reg, idx_next;
    logic [dmwc_pkg::NUM_LINES-1:0]     init_reg, init_next;
    dmwc_pkg::rsp_t                     res0_reg, res0_next;
    dmwc_pkg::rsp_t                     res1_reg, res1_next;
    logic                               res_two_reg, res_two_next;
    logic                               res_sel_reg, res_sel_next;
    logic                               hold_valid_reg, hold_valid_next;
    logic                               pend_reg, pend_next;
    logic                               pend_cach_reg, pend_cach_next;
    logic [31:0]                        pend_addr_reg, pend_addr_next;
    logic                               out_valid_reg, out_valid_next;
    dmwc_pkg::rsp_t                     out_reg, out_next;

    dmwc_pkg::line_t                    mem [dmwc_pkg::NUM_LINES];
    dmwc_pkg::line_t                    mem_q;
    dmwc_pkg::line_t                    mem_wd;
    logic                               mem_we;
    logic                               mem_re;
    logic [dmwc_pkg::IDX_W-1:0]         mem_ra;

    dmwc_pkg::line_t                    ln;
    dmwc_pkg::rsp_t                     rd_req;
    logic [31:0]                        tgt;
    logic                               out_free;
    logic                               hit;
    logic                               wb;
    logic                               found;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;

    // line store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= mem_wd;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_ra];
        end
    end

    // a line never written since reset reads as all zero
    assign ln = init_reg[idx_reg] ? mem_q : '0;

    assign tgt = (req.mode == dmwc_pkg::MODE_FILL) ? pend_addr_reg : req.address;

    always_comb
    begin
        rd_req.kind        = dmwc_pkg::KIND_BUS_READ;
        rd_req.out_address = item_reg.address;
        rd_req.out_data    = '0;
        rd_req.out_mask    = '0;
        rd_req.last        = 1'b1;
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        idx_next        = idx_reg;
        init_next       = init_reg;
        res0_next       = res0_reg;
        res1_next       = res1_reg;
        res_two_next    = res_two_reg;
        res_sel_next    = res_sel_reg;
        hold_valid_next = hold_valid_reg;
        pend_next       = pend_reg;
        pend_cach_next  = pend_cach_reg;
        pend_addr_next  = pend_addr_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_wd          = ln;
        mem_re          = 1'b0;
        mem_ra          = '0;
        hit             = (ln.mask == dmwc_pkg::FULL_MASK) && (ln.addr == item_reg.address);
        wb              = 1'b0;
        found           = (ln.mask != '0) && ln.dirty;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next         = req;
                    item_next.address = tgt;
                    mem_re            = 1'b1;
                    if (req.mode == dmwc_pkg::MODE_FLUSH)
                    begin
                        idx_next        = '0;
                        mem_ra          = '0;
                        hold_valid_next = 1'b0;
                        state_next      = S_FLUSH_CHK;
                    end
                    else
                    begin
                        idx_next   = tgt[dmwc_pkg::IDX_W+1:2];
                        mem_ra     = tgt[dmwc_pkg::IDX_W+1:2];
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC:
            begin
                state_next   = S_IDLE;
                res_sel_next = 1'b0;
                res_two_next = 1'b0;
                case (item_reg.mode)
                    dmwc_pkg::MODE_READ:
                    begin
                        state_next     = S_EMIT;
                        res0_next      = rd_req;
                        pend_next      = 1'b1;
                        pend_cach_next = item_reg.cacheable;
                        pend_addr_next = item_reg.address;
                        if (item_reg.cacheable)
                        begin
                            if (hit)
                            begin
                                res0_next = '{kind: dmwc_pkg::KIND_READ_DATA,
                                              out_address: item_reg.address,
                                              out_data: ln.word, out_mask: '0, last: 1'b1};
                                pend_next      = pend_reg;
                                pend_cach_next = pend_cach_reg;
                                pend_addr_next = pend_addr_reg;
                            end
                            else if (found)
                            begin
                                res0_next = '{kind: dmwc_pkg::KIND_BUS_WRITE,
                                              out_address: ln.addr, out_data: ln.word,
                                              out_mask: ln.mask, last: 1'b0};
                                res1_next    = rd_req;
                                res_two_next = 1'b1;
                                mem_we       = 1'b1;
                                mem_wd.dirty = 1'b0;
                            end
                        end
                    end

                    dmwc_pkg::MODE_WRITE:
                    begin
                        if (item_reg.cacheable)
                        begin
                            wb = (ln.addr != item_reg.address) && found;
                            if (wb)
                            begin
                                state_next = S_EMIT;
                                res0_next  = '{kind: dmwc_pkg::KIND_BUS_WRITE,
                                               out_address: ln.addr, out_data: ln.word,
                                               out_mask: ln.mask, last: 1'b1};
                            end
                            mem_we       = 1'b1;
                            mem_wd.addr  = item_reg.address;
                            mem_wd.dirty = 1'b1;
                            if (ln.addr == item_reg.address)
                            begin
                                mem_wd.word = (ln.word & ~item_reg.write_mask)
                                            | (item_reg.write_data & item_reg.write_mask);
                                mem_wd.mask = ln.mask | item_reg.write_mask;
                            end
                            else
                            begin
                                mem_wd.word = item_reg.write_data;
                                mem_wd.mask = item_reg.write_mask;
                            end
                            init_next[idx_reg] = 1'b1;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                            res0_next  = '{kind: dmwc_pkg::KIND_BUS_WRITE,
                                           out_address: item_reg.address,
                                           out_data: item_reg.write_data,
                                           out_mask: item_reg.write_mask, last: 1'b1};
                        end
                    end

                    dmwc_pkg::MODE_FILL:
                    begin
                        if (pend_reg)
                        begin
                            state_next = S_EMIT;
                            res0_next  = '{kind: dmwc_pkg::KIND_READ_DATA,
                                           out_address: item_reg.address,
                                           out_data: item_reg.memory_data,
                                           out_mask: '0, last: 1'b1};
                            if (pend_cach_reg)
                            begin
                                mem_we             = 1'b1;
                                mem_wd             = '{addr: item_reg.address,
                                                       word: item_reg.memory_data,
                                                       mask: dmwc_pkg::FULL_MASK,
                                                       dirty: 1'b0};
                                init_next[idx_reg] = 1'b1;
                            end
                            pend_next      = 1'b0;
                            pend_cach_next = 1'b0;
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_sel_reg ? res1_reg : res0_reg;
                    if (res_sel_reg || !res_two_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        res_sel_next = 1'b1;
                    end
                end
            end

            S_FLUSH_CHK:
            begin
                if (!(found && hold_valid_reg && !out_free))
                begin
                    if (found)
                    begin
                        mem_we      = 1'b1;
                        mem_wd.mask = '0;
                        mem_wd.dirty = 1'b0;
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = res0_reg;
                        end
                        res0_next = '{kind: dmwc_pkg::KIND_BUS_WRITE,
                                      out_address: ln.addr, out_data: ln.word,
                                      out_mask: ln.mask, last: 1'b0};
                        hold_valid_next = 1'b1;
                    end
                    if (idx_reg == dmwc_pkg::IDX_W'(dmwc_pkg::NUM_LINES - 1))
                    begin
                        state_next = S_FLUSH_END;
                    end
                    else
                    begin
                        idx_next = idx_reg + dmwc_pkg::IDX_W'(1);
                        mem_re   = 1'b1;
                        mem_ra   = idx_reg + dmwc_pkg::IDX_W'(1);
                    end
                end
            end

            S_FLUSH_END:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = res0_reg;
                    out_next.last   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            item_reg       <= '0;
            idx_reg        <= '0;
            init_reg       <= '0;
            res0_reg       <= '0;
            res1_reg       <= '0;
            res_two_reg    <= 1'b0;
            res_sel_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
            pend_reg       <= 1'b0;
            pend_cach_reg  <= 1'b0;
            pend_addr_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            item_reg       <= item_next;
            idx_reg        <= idx_next;
            init_reg       <= init_next;
            res0_reg       <= res0_next;
            res1_reg       <= res1_next;
            res_two_reg    <= res_two_next;
            res_sel_reg    <= res_sel_next;
            hold_valid_reg <= hold_valid_next;
            pend_reg       <= pend_next;
            pend_cach_reg  <= pend_cach_next;
            pend_addr_reg  <= pend_addr_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

endmodule

// File: rtl/core/dmwc_checker.sv
// dmwc_checker: port-level assertions for the direct-mapped write-back word cache
// bound to direct_mapped_writeback_word_cache_unit at the end of this file
// depends on dmwc_pkg
module dmwc_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  dmwc_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  dmwc_pkg::rsp_t rsp
);

    // a stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("rsp item changed under stall");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("req taken while busy");

    // a bus read request always ends its item
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind == dmwc_pkg::KIND_BUS_READ) |-> rsp.last)
        else $error("bus read request not last");

    // only bus writes carry a mask, and no undefined kind appears
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind != dmwc_pkg::KIND_BUS_WRITE) |->
            (rsp.out_mask == '0) && ((rsp.kind == dmwc_pkg::KIND_BUS_READ) ||
                                     (rsp.kind == dmwc_pkg::KIND_READ_DATA)))
        else $error("bad mask or kind on rsp item");

    // an input accepted while no rsp item is shown makes none appear before the line is read
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
        else $error("rsp item without delay after req");

endmodule

bind direct_mapped_writeback_word_cache_unit dmwc_checker u_dmwc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
